// ===== design/escape_sequence_unescaper_defines.svh =====
// Assertion macros used by the checker file of the unescaper.
`ifndef ESCAPE_SEQUENCE_UNESCAPER_DEFINES_SVH
`define ESCAPE_SEQUENCE_UNESCAPER_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define ESU_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked through reset as well.
`define ESU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/esu_pkg.sv =====
// Shared types and sizes of the escape sequence unescaper.
package esu_pkg;

    localparam int ESU_MAX_RES = 3;
    localparam int ESU_QDEPTH  = 4;
    localparam int ESU_QPTR_W  = $clog2(ESU_QDEPTH);
    localparam int ESU_QCNT_W  = $clog2(ESU_QDEPTH + 1);

    // Decoded bytes caused by one input beat.
    typedef struct packed {
        logic [ESU_MAX_RES-1:0][7:0] bytes;
        logic [1:0]                  last;   // index of the final byte in the group
        logic                        fin;    // group closes the string
    } t_entry;

    // Write side of the queue, driven by the front end.
    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_q_wr;

    // Read side of the queue, seen by the back end.
    typedef struct packed {
        logic   empty;
        t_entry head;
    } t_q_rd;

endpackage

// ===== design/esu_stream_if.sv =====
// Stream interfaces for the raw input bytes and the decoded output bytes.
interface esu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_final;

    modport source (output valid, output in_byte, output in_final, input ready);
    modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface esu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_string_end;

    modport source (output valid, output out_byte, output out_run_last,
                    output out_string_end, input ready);
    modport sink   (input valid, input out_byte, input out_run_last,
                    input out_string_end, output ready);
endinterface

// ===== design/escape_sequence_unescaper.sv =====
// Top level of the escape sequence unescaper.
//
//   channel  dir  beat
//   i_in     in   one raw byte of the string, in_final on its last byte
//   o_out    out  one decoded byte, run-last and string-end flags
//
// One raw byte is accepted per cycle while the four-group queue has room.
// The back end gives one decoded byte per cycle while its output is taken,
// so a byte that expands to two or three results takes that many beats; the
// queue fills and the input stalls when expansions run on or the output is
// held off. An accepted byte is written to the queue and then to the output
// register. Synchronous active-low reset returns the decoder to normal mode
// and empties the queue and the output register.
module escape_sequence_unescaper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esu_in_if.sink    i_in,
    esu_out_if.source o_out
);

    esu_pkg::t_q_wr q_wr;
    esu_pkg::t_q_rd q_rd;
    logic           q_full;
    logic           q_pop;

    esu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_wr   (q_wr)
    );

    esu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (q_wr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_q_rd  (q_rd)
    );

    esu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_rd  (q_rd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// ===== design/esu_front.sv =====
// Front end: accepts raw bytes, tracks the escape state, groups decoded bytes.
module esu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    esu_in_if.sink        i_in,
    input  logic          i_q_full,
    output esu_pkg::t_q_wr o_q_wr
);

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_ESC    = 4'b0010,
        MODE_HEX    = 4'b0100,
        MODE_OCT    = 4'b1000
    } t_mode;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CODE_LF   = 8'h0A;
    localparam logic [7:0] CODE_CR   = 8'h0D;
    localparam logic [7:0] CODE_FF   = 8'h0C;
    localparam logic [7:0] CODE_BS   = 8'h08;

    // Bit 4 flags a hex digit, bits 3:0 give its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    t_mode      r_mode, n_mode;
    logic [7:0] r_val,  n_val;
    logic [1:0] r_cnt,  n_cnt;

    logic                                      accept;
    logic [2:0]                                k;
    logic [esu_pkg::ESU_MAX_RES-1:0][7:0]      res;
    logic                                      do_plain;
    logic [4:0]                                hx;
    logic [7:0]                                c;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign c          = i_in.in_byte;

    always_comb begin
        n_mode   = r_mode;
        n_val    = r_val;
        n_cnt    = r_cnt;
        k        = 3'd0;
        res      = '0;
        do_plain = 1'b0;
        hx       = hex_value(c);

        unique case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_NORMAL;
                unique case (c)
                    CH_N: begin res[k[1:0]] = CODE_LF; k = k + 3'd1; end
                    CH_R: begin res[k[1:0]] = CODE_CR; k = k + 3'd1; end
                    CH_F: begin res[k[1:0]] = CODE_FF; k = k + 3'd1; end
                    CH_B: begin res[k[1:0]] = CODE_BS; k = k + 3'd1; end
                    CH_X: begin
                        n_mode = MODE_HEX;
                        n_val  = 8'd0;
                        n_cnt  = 2'd0;
                    end
                    CH_ZERO: begin
                        n_mode = MODE_OCT;
                        n_val  = 8'd0;
                        n_cnt  = 2'd0;
                    end
                    CH_BSLASH: begin
                        res[k[1:0]] = CH_BSLASH; k = k + 3'd1;
                        res[k[1:0]] = CH_BSLASH; k = k + 3'd1;
                    end
                    default: begin res[k[1:0]] = c; k = k + 3'd1; end
                endcase
            end
            MODE_HEX: begin
                if (hx[4]) begin
                    n_val = {r_val[3:0], hx[3:0]};
                    n_cnt = r_cnt + 2'd1;
                    if (n_cnt >= 2'd2) begin
                        res[k[1:0]] = n_val; k = k + 3'd1;
                        n_mode = MODE_NORMAL;
                        n_val  = 8'd0;
                        n_cnt  = 2'd0;
                    end
                end else begin
                    if (r_cnt == 2'd0) begin
                        res[k[1:0]] = CH_BSLASH; k = k + 3'd1;
                        res[k[1:0]] = CH_X;      k = k + 3'd1;
                    end else begin
                        res[k[1:0]] = r_val; k = k + 3'd1;
                    end
                    n_mode   = MODE_NORMAL;
                    n_val    = 8'd0;
                    n_cnt    = 2'd0;
                    do_plain = 1'b1;
                end
            end
            MODE_OCT: begin
                if (c >= CH_ZERO && c <= CH_SEVEN) begin
                    n_val = {r_val[4:0], c[2:0]};
                    n_cnt = r_cnt + 2'd1;
                    if (n_cnt >= 2'd3) begin
                        res[k[1:0]] = n_val; k = k + 3'd1;
                        n_mode = MODE_NORMAL;
                        n_val  = 8'd0;
                        n_cnt  = 2'd0;
                    end
                end else begin
                    res[k[1:0]] = r_val; k = k + 3'd1;
                    n_mode   = MODE_NORMAL;
                    n_val    = 8'd0;
                    n_cnt    = 2'd0;
                    do_plain = 1'b1;
                end
            end
            default: begin
                n_mode   = MODE_NORMAL;
                do_plain = 1'b1;
            end
        endcase

        // Byte that ended a digit run, or a byte in normal mode.
        if (do_plain) begin
            if (c == CH_BSLASH) begin
                n_mode = MODE_ESC;
            end else begin
                res[k[1:0]] = c; k = k + 3'd1;
            end
        end

        // Flush whatever escape is still open at the end of the string.
        if (i_in.in_final) begin
            priority case (n_mode)
                MODE_ESC: begin res[k[1:0]] = CH_BSLASH; k = k + 3'd1; end
                MODE_HEX: begin
                    if (n_cnt == 2'd0) begin
                        res[k[1:0]] = CH_BSLASH; k = k + 3'd1;
                        res[k[1:0]] = CH_X;      k = k + 3'd1;
                    end else begin
                        res[k[1:0]] = n_val; k = k + 3'd1;
                    end
                end
                MODE_OCT: begin res[k[1:0]] = n_val; k = k + 3'd1; end
                default: ;
            endcase
            n_mode = MODE_NORMAL;
            n_val  = 8'd0;
            n_cnt  = 2'd0;
        end
    end

    always_comb begin
        o_q_wr.push        = accept && (k != 3'd0);
        o_q_wr.entry.bytes = res;
        o_q_wr.entry.last  = 2'(k - 3'd1);
        o_q_wr.entry.fin   = i_in.in_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_val  <= 8'd0;
            r_cnt  <= 2'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_val  <= n_val;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== design/esu_fifo.sv =====
// Short queue of decoded byte groups between the front and back ends.
module esu_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  esu_pkg::t_q_wr i_q_wr,
    input  logic           i_pop,
    output logic           o_full,
    output esu_pkg::t_q_rd o_q_rd
);

    esu_pkg::t_entry                 r_mem [esu_pkg::ESU_QDEPTH];
    logic [esu_pkg::ESU_QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [esu_pkg::ESU_QCNT_W-1:0]  r_count;
    logic                            do_push, do_pop;

    assign o_full        = (r_count == esu_pkg::ESU_QCNT_W'(esu_pkg::ESU_QDEPTH));
    assign o_q_rd.empty  = (r_count == '0);
    assign o_q_rd.head   = r_mem[r_rd_ptr];
    assign do_push       = i_q_wr.push && !o_full;
    assign do_pop        = i_pop && !o_q_rd.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_q_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/esu_back.sv =====
// Back end: unpacks each queued group into single output beats.
module esu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  esu_pkg::t_q_rd i_q_rd,
    output logic           o_pop,
    esu_out_if.source      o_out
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_end;
    logic [1:0] r_idx;

    logic       load;
    logic       take;
    logic       at_last;

    assign load    = !r_valid || o_out.ready;
    assign take    = load && !i_q_rd.empty;
    assign at_last = (r_idx == i_q_rd.head.last);
    assign o_pop   = take && at_last;

    assign o_out.valid          = r_valid;
    assign o_out.out_byte       = r_byte;
    assign o_out.out_run_last   = r_run_last;
    assign o_out.out_string_end = r_end;

    // Output register: refill when it is empty or its current beat is taken.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte     <= i_q_rd.head.bytes[r_idx];
            r_run_last <= at_last;
            r_end      <= at_last && i_q_rd.head.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_q_rd.empty;
            if (take) begin
                r_idx <= at_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

endmodule

// ===== design/esu_checker.sv =====
// Port-level checks of the unescaper and their bind to the top level.
`include "escape_sequence_unescaper_defines.svh"

module esu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_run_last,
    input logic       i_out_string_end
);

    `ESU_ASSERT_ALWAYS(a_reset_clears_out, i_clk,
        !i_rst_n |=> !i_out_valid, "output valid after reset")
    `ESU_ASSERT_CLK(a_end_is_run_last, i_clk, i_rst_n,
        i_out_valid && i_out_string_end |-> i_out_run_last, "string end without run last")
    `ESU_ASSERT_CLK(a_stall_holds_valid, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid, "output beat dropped while stalled")
    `ESU_ASSERT_CLK(a_stall_holds_data, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_run_last)
        && $stable(i_out_string_end), "output beat changed while stalled")

endmodule

bind escape_sequence_unescaper esu_checker u_esu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_run_last   (o_out.out_run_last),
    .i_out_string_end (o_out.out_string_end)
);

// ===== bench/escape_sequence_unescaper_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the escape sequence unescaper: directed strings, stalls, random strings.
module escape_sequence_unescaper_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;

    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_R      = "r";
    localparam logic [7:0] CH_F      = "f";
    localparam logic [7:0] CH_B      = "b";
    localparam logic [7:0] CH_X      = "x";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_SEVEN  = "7";
    localparam logic [7:0] CC_LF     = 8'h0a;
    localparam logic [7:0] CC_CR     = 8'h0d;
    localparam logic [7:0] CC_FF     = 8'h0c;
    localparam logic [7:0] CC_BS     = 8'h08;

    typedef enum logic [2:0] {
        DEC_NORMAL = 3'd0,
        DEC_ESC    = 3'd1,
        DEC_HEX    = 3'd2,
        DEC_OCT    = 3'd3
    } t_dec_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
    } t_decoded;

    logic i_clk;
    logic i_rst_n;

    esu_in_if  in_ch ();
    esu_out_if out_ch ();

    escape_sequence_unescaper uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Decoder state mirrored by the predictor
    t_dec_mode  dec_mode;
    logic [8:0] dig_val;
    logic [1:0] dig_cnt;
    logic [7:0] pend_bytes [3];
    int         pend_n;

    t_decoded   decoded_q [$];
    logic [7:0] raw_q [$];
    int         beats_sent;
    int         fail_count;
    bit         src_idle_on;
    bit         sink_idle_on;
    int         sink_hold_len;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int hex_value(input logic [7:0] chr);
        if (chr >= "0" && chr <= "9") return chr - "0";
        if (chr >= "a" && chr <= "f") return chr - "a" + 10;
        if (chr >= "A" && chr <= "F") return chr - "A" + 10;
        return -1;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        pend_bytes[pend_n] = b;
        pend_n++;
    endfunction

    function automatic void take_plain(input logic [7:0] chr);
        if (chr == CH_BSLASH) begin
            dec_mode = DEC_ESC;
        end else begin
            add_byte(chr);
        end
    endfunction

    // Give what an open escape holds and return to normal mode
    function automatic void flush_escape();
        case (dec_mode)
            DEC_ESC: begin
                add_byte(CH_BSLASH);
            end
            DEC_HEX: begin
                if (dig_cnt == 2'd0) begin
                    add_byte(CH_BSLASH);
                    add_byte(CH_X);
                end else begin
                    add_byte(dig_val[7:0]);
                end
            end
            DEC_OCT: begin
                add_byte(dig_val[7:0]);
            end
            default: ;
        endcase
        dec_mode = DEC_NORMAL;
        dig_val  = '0;
        dig_cnt  = '0;
    endfunction

    function automatic void predict_decoded(input logic [7:0] chr, input logic fin);
        int       h;
        t_decoded d;
        pend_n = 0;
        case (dec_mode)
            DEC_ESC: begin
                dec_mode = DEC_NORMAL;
                case (chr)
                    CH_N:      add_byte(CC_LF);
                    CH_R:      add_byte(CC_CR);
                    CH_F:      add_byte(CC_FF);
                    CH_B:      add_byte(CC_BS);
                    CH_X: begin
                        dec_mode = DEC_HEX;
                        dig_val  = '0;
                        dig_cnt  = '0;
                    end
                    CH_ZERO: begin
                        dec_mode = DEC_OCT;
                        dig_val  = '0;
                        dig_cnt  = '0;
                    end
                    CH_BSLASH: begin
                        add_byte(CH_BSLASH);
                        add_byte(CH_BSLASH);
                    end
                    default:   add_byte(chr);
                endcase
            end
            DEC_HEX: begin
                h = hex_value(chr);
                if (h >= 0) begin
                    dig_val = {dig_val[4:0], h[3:0]};
                    dig_cnt = dig_cnt + 2'd1;
                    if (dig_cnt >= 2'd2) flush_escape();
                end else begin
                    flush_escape();
                    take_plain(chr);
                end
            end
            DEC_OCT: begin
                if (chr >= CH_ZERO && chr <= CH_SEVEN) begin
                    dig_val = {dig_val[5:0], chr[2:0]};
                    dig_cnt = dig_cnt + 2'd1;
                    if (dig_cnt >= 2'd3) flush_escape();
                end else begin
                    flush_escape();
                    take_plain(chr);
                end
            end
            default: begin
                dec_mode = DEC_NORMAL;
                take_plain(chr);
            end
        endcase
        if (fin) flush_escape();
        for (int i = 0; i < pend_n; i++) begin
            d.data       = pend_bytes[i];
            d.run_last   = (i == pend_n - 1);
            d.string_end = fin && (i == pend_n - 1);
            decoded_q.push_back(d);
        end
    endfunction

    // Offer one beat after an optional gap and hold it until accepted
    task automatic send_beat(input logic [7:0] chr, input logic fin);
        int gap;
        @(negedge i_clk);
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.in_byte  = chr;
        in_ch.in_final = fin;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_decoded(chr, fin);
        beats_sent++;
    endtask

    task automatic send_raw();
        for (int i = 0; i < raw_q.size(); i++) send_beat(raw_q[i], i == raw_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
    endtask

    // Drop valid and wait until every predicted byte has come out
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void add_token();
        int kind;
        int v;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            raw_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 5) begin
            raw_q.push_back(CH_BSLASH);
            case ($urandom_range(0, 5))
                0:       raw_q.push_back(CH_N);
                1:       raw_q.push_back(CH_R);
                2:       raw_q.push_back(CH_F);
                3:       raw_q.push_back(CH_B);
                4:       raw_q.push_back(CH_BSLASH);
                default: raw_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end else if (kind < 7) begin
            raw_q.push_back(CH_BSLASH);
            raw_q.push_back(CH_X);
            repeat ($urandom_range(0, 2)) begin
                v = $urandom_range(0, 21);
                if (v < 10)      raw_q.push_back(8'("0" + v));
                else if (v < 16) raw_q.push_back(8'("a" + v - 10));
                else             raw_q.push_back(8'("A" + v - 16));
            end
        end else if (kind < 9) begin
            raw_q.push_back(CH_BSLASH);
            raw_q.push_back(CH_ZERO);
            repeat ($urandom_range(0, 3)) raw_q.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
        end else begin
            raw_q.push_back(CH_BSLASH);
        end
    endfunction

    function automatic void build_random_string();
        int ntok;
        raw_q.delete();
        ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        repeat (ntok) add_token();
    endfunction

    task automatic test_plain_extremes();
        raw_q.delete();
        raw_q.push_back(8'h00);
        raw_q.push_back(8'hff);
        send_raw();
    endtask

    task automatic test_simple_escapes();
        send_text("\\n\\r\\f\\b\\\\\\q");
    endtask

    // Full hex, hex with no digit, hex cut by a backslash, trailing backslash
    task automatic test_hex_escapes();
        send_text("\\x4F\\xg\\x5\\");
    endtask

    // Octal masked to 8 bits, octal cut early, escapes open at the final byte
    task automatic test_octal_and_flush();
        send_text("\\0777\\01z\\05");
        send_text("\\x");
    endtask

    // Hold the output long while the input keeps offering, so the queue fills
    task automatic test_output_stall();
        src_idle_on   = 1'b0;
        sink_idle_on  = 1'b0;
        sink_hold_len = HOLD_CYCLES;
        raw_q.delete();
        while (raw_q.size() < 24) add_token();
        send_raw();
    endtask

    task automatic test_random_strings(input int n_items, input bit src_idle,
                                       input bit sink_idle);
        int stop_at;
        src_idle_on  = src_idle;
        sink_idle_on = sink_idle;
        stop_at      = beats_sent + n_items;
        while (beats_sent < stop_at) begin
            build_random_string();
            send_raw();
        end
    endtask

    // Output side: random stalls, plus a long hold when one is requested
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_len > 0) begin
                out_ch.ready  = 1'b0;
                n             = sink_hold_len;
                sink_hold_len = 0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                n = sink_idle_on ? pick_gap() : 0;
                if (n > 0) begin
                    out_ch.ready = 1'b0;
                    repeat (n - 1) @(negedge i_clk);
                end else begin
                    out_ch.ready = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_decoded exp_d;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected beat: out_byte %02h", out_ch.out_byte);
                fail_count++;
            end else begin
                exp_d = decoded_q.pop_front();
                if (out_ch.out_byte !== exp_d.data) begin
                    $error("out_byte: expected %02h, got %02h", exp_d.data, out_ch.out_byte);
                    fail_count++;
                end
                if (out_ch.out_run_last !== exp_d.run_last) begin
                    $error("out_run_last: expected %0b, got %0b",
                           exp_d.run_last, out_ch.out_run_last);
                    fail_count++;
                end
                if (out_ch.out_string_end !== exp_d.string_end) begin
                    $error("out_string_end: expected %0b, got %0b",
                           exp_d.string_end, out_ch.out_string_end);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("escape_sequence_unescaper test failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = '0;
        in_ch.in_final = 1'b0;
        dec_mode       = DEC_NORMAL;
        dig_val        = '0;
        dig_cnt        = '0;
        pend_n         = 0;
        beats_sent     = 0;
        fail_count     = 0;
        src_idle_on    = 1'b0;
        sink_idle_on   = 1'b0;
        sink_hold_len  = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_extremes();
        test_simple_escapes();
        test_hex_escapes();
        test_octal_and_flush();
        wait_drained();

        test_output_stall();
        wait_drained();

        test_random_strings(60, 1'b0, 1'b0);
        wait_drained();
        test_random_strings(220, 1'b1, 1'b1);
        wait_drained();
        test_random_strings(40, 1'b1, 1'b0);
        test_random_strings(40, 1'b0, 1'b1);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && decoded_q.size() == 0) begin
            $display("escape_sequence_unescaper test passed");
        end else begin
            $display("escape_sequence_unescaper test failed");
        end
        $finish;
    end

endmodule
